// ===== hdl/lru_pkg.sv =====
// lru_pkg: shared widths, entry type, state codes and cell control bundle
// for the recency list evictor; no dependencies
`default_nettype none

package lru_pkg;

	localparam int MAX_ENTRIES = 64;
	localparam int IDX_W       = $clog2(MAX_ENTRIES);
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
	localparam int KIND_W      = 2;
	localparam int ID_W        = 31;
	localparam int LIMIT_W     = 7;
	localparam int LCMP_W      = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

	localparam logic [LIMIT_W-1:0] CAPACITY_RESET = LIMIT_W'(50);

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [ID_W-1:0]   id;
	} entry_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_UPD  = 2'b10
	} state_t;

	// broadcast to every cell during the update cycle
	typedef struct packed {
		logic             hit;
		logic             evict;
		logic [IDX_W-1:0] pos;
		logic [CNT_W-1:0] last;
	} cell_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/lru_if.sv =====
// lru_if: request, response and capacity write channels
// depends on lru_pkg
`default_nettype none

interface lru_req_if;
	import lru_pkg::*;
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] entry_kind;
	logic [ID_W-1:0]   entry_id;
	modport source (output valid, output entry_kind, output entry_id, input ready);
	modport sink   (input valid, input entry_kind, input entry_id, output ready);
endinterface

interface lru_rsp_if;
	import lru_pkg::*;
	logic              valid;
	logic              ready;
	logic              evicted_valid;
	logic [KIND_W-1:0] evicted_kind;
	logic [ID_W-1:0]   evicted_id;
	logic              was_hit;
	modport source (output valid, output evicted_valid, output evicted_kind,
		output evicted_id, output was_hit, input ready);
	modport sink   (input valid, input evicted_valid, input evicted_kind,
		input evicted_id, input was_hit, output ready);
endinterface

interface lru_cfg_if;
	import lru_pkg::*;
	logic               valid;
	logic               ready;
	logic [LIMIT_W-1:0] capacity_limit;
	modport source (output valid, output capacity_limit, input ready);
	modport sink   (input valid, input capacity_limit, output ready);
endinterface

`default_nettype wire

// ===== hdl/lru_cell.sv =====
// lru_cell: one slot of the recency list, compares against a request and
// shifts towards the old end; depends on lru_pkg
`default_nettype none

module lru_cell (
	input  wire logic                  clk,
	input  wire logic [lru_pkg::CNT_W-1:0] idx,
	input  wire logic [lru_pkg::CNT_W-1:0] count,
	input  wire logic                  cmp_en,
	input  wire lru_pkg::entry_t       cmp_key,
	input  wire logic                  upd_en,
	input  wire lru_pkg::entry_t       new_key,
	input  wire lru_pkg::cell_ctl_t    ctl,
	input  wire lru_pkg::entry_t       nxt1,
	input  wire lru_pkg::entry_t       nxt2,
	output lru_pkg::entry_t            value,
	output logic                       match
);
	import lru_pkg::*;

	entry_t           value_q;
	logic             match_q;
	logic [CNT_W-1:0] src;
	entry_t           value_d;

	// slot of the post-access list that lands here
	assign src = ctl.evict ? idx + CNT_W'(1) : idx;

	always_comb begin
		if (src == ctl.last) begin
			value_d = new_key;
		end else if (ctl.hit && (src >= CNT_W'(ctl.pos))) begin
			value_d = ctl.evict ? nxt2 : nxt1;
		end else begin
			value_d = ctl.evict ? nxt1 : value_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmp_en) begin
			match_q <= (idx < count) && (value_q == cmp_key);
		end
		if (upd_en) begin
			value_q <= value_d;
		end
	end

	assign value = value_q;
	assign match = match_q;

endmodule

`default_nettype wire

// ===== hdl/lru_recency_list_evictor.sv =====
// lru_recency_list_evictor: recency list evictor top level, a row of
// lru_cell slots with the shared count and response register
// depends on lru_pkg, lru_if and lru_cell
//
// usage
// - req carries one access (entry_kind, entry_id); rsp returns exactly one
//   response per request: was_hit, and the evicted entry when the list grew
//   past the capacity limit (kind and id read zero when nothing is evicted)
// - cfg writes capacity_limit; it is always ready; write it only while idle, the block does not enforce this
// - each request passes the acceptance edge, where every slot compares
//   against the request in parallel, and then the update edge, where the
//   slots take their new contents and the response register loads
// - the response is valid from the update edge on; a new request is taken
//   only once the compare/update sequence of the last one is done
// - a response held by a stalled receiver stays put; no new request is
//   taken until it is gone or is being taken in the same cycle
// - after reset the list is empty and capacity_limit is 50; slot contents
//   beyond the list length are never used
`default_nettype none

module lru_recency_list_evictor (
	input  wire logic   clk,
	input  wire logic   arst_n,
	lru_req_if.sink     req,
	lru_rsp_if.source   rsp,
	lru_cfg_if.sink     cfg
);
	import lru_pkg::*;

	state_t             st_q;
	logic [CNT_W-1:0]   count_q;
	logic [LIMIT_W-1:0] limit_q;
	entry_t             key_q;
	logic               rsp_valid_q;
	logic               evicted_valid_q;
	entry_t             evicted_q;
	logic               was_hit_q;

	entry_t             vals  [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0] match;
	entry_t             cmp_key;
	logic               accept;
	logic               upd;
	cell_ctl_t          ctl;
	logic [IDX_W-1:0]   hit_pos;
	logic               hit_any;
	logic [CNT_W-1:0]   last_slot;
	logic               evict;
	logic [CNT_W-1:0]   count_grown;
	logic [LCMP_W-1:0]  limit_eff;
	entry_t             victim;

	assign cmp_key = '{kind: req.entry_kind, id: req.entry_id};
	assign req.ready = (st_q == ST_IDLE) && (!rsp_valid_q || rsp.ready);
	assign accept = req.valid && req.ready;
	assign upd = (st_q == ST_UPD);
	assign cfg.ready = 1'b1;

	// hit position from the one-hot match vector
	always_comb begin
		hit_pos = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			if (match[i]) begin
				hit_pos = hit_pos | IDX_W'(i);
			end
		end
	end

	assign hit_any     = |match;
	assign last_slot   = hit_any ? count_q - CNT_W'(1) : count_q;
	assign count_grown = hit_any ? count_q : count_q + CNT_W'(1);
	assign limit_eff   = (LCMP_W'(limit_q) > LCMP_W'(MAX_ENTRIES)) ?
		LCMP_W'(MAX_ENTRIES) : LCMP_W'(limit_q);
	assign evict       = LCMP_W'(count_grown) > limit_eff;
	assign ctl         = '{hit: hit_any, evict: evict, pos: hit_pos, last: last_slot};

	always_comb begin
		if (ctl.last == '0) begin
			victim = key_q;
		end else if (ctl.hit && (ctl.pos == '0)) begin
			victim = vals[1];
		end else begin
			victim = vals[0];
		end
	end

	for (genvar gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
		entry_t nxt1;
		entry_t nxt2;
		if (gi + 1 < MAX_ENTRIES) begin : g_n1
			assign nxt1 = vals[gi+1];
		end else begin : g_n1_end
			assign nxt1 = '0;
		end
		if (gi + 2 < MAX_ENTRIES) begin : g_n2
			assign nxt2 = vals[gi+2];
		end else begin : g_n2_end
			assign nxt2 = '0;
		end
		lru_cell u_cell (
			.clk     (clk),
			.idx     (CNT_W'(gi)),
			.count   (count_q),
			.cmp_en  (accept),
			.cmp_key (cmp_key),
			.upd_en  (upd),
			.new_key (key_q),
			.ctl     (ctl),
			.nxt1    (nxt1),
			.nxt2    (nxt2),
			.value   (vals[gi]),
			.match   (match[gi])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			count_q     <= '0;
			limit_q     <= CAPACITY_RESET;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				limit_q <= cfg.capacity_limit;
			end
			case (st_q)
				ST_IDLE: begin
					if (accept) begin
						st_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					st_q    <= ST_IDLE;
					count_q <= count_grown - CNT_W'(ctl.evict);
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
			if (upd) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= cmp_key;
		end
		if (upd) begin
			evicted_valid_q <= ctl.evict;
			evicted_q       <= ctl.evict ? victim : '0;
			was_hit_q       <= ctl.hit;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.evicted_valid = evicted_valid_q;
	assign rsp.evicted_kind  = evicted_q.kind;
	assign rsp.evicted_id    = evicted_q.id;
	assign rsp.was_hit       = was_hit_q;

endmodule

`default_nettype wire

// ===== hdl/lru_checker.sv =====
// lru_checker: port-level assertions for the recency list evictor, bound
// to the top level; depends on lru_pkg
`default_nettype none

module lru_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       req_valid,
	input wire logic                       req_ready,
	input wire logic                       rsp_valid,
	input wire logic                       rsp_ready,
	input wire logic                       evicted_valid,
	input wire logic [lru_pkg::KIND_W-1:0] evicted_kind,
	input wire logic [lru_pkg::ID_W-1:0]   evicted_id,
	input wire logic                       was_hit
);
	import lru_pkg::*;

	logic req_acc;
	assign req_acc = req_valid && req_ready;

	// stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(evicted_valid)
		&& $stable(evicted_kind) && $stable(evicted_id) && $stable(was_hit))
		else $error("stalled response changed");

	// one request at a time
	a_no_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> !req_ready)
		else $error("request taken during update");

	// a response is valid after every accepted request
	a_rsp_latency: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |-> ##2 rsp_valid)
		else $error("response missing after request");

	// no response without a request
	a_rsp_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_acc, 2))
		else $error("response without request");

	// empty eviction fields read zero
	a_evict_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !evicted_valid |-> (evicted_kind == '0) && (evicted_id == '0))
		else $error("eviction fields set without eviction");

endmodule

bind lru_recency_list_evictor lru_checker u_lru_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.evicted_valid (rsp.evicted_valid),
	.evicted_kind  (rsp.evicted_kind),
	.evicted_id    (rsp.evicted_id),
	.was_hit       (rsp.was_hit)
);

`default_nettype wire

// ===== sim/tb_lru_recency_list_evictor.sv =====
// tb_lru_recency_list_evictor: self-checking bench for the recency list evictor,
// with a queue-fed request driver, a response monitor and an in-bench list predictor
// depends on lru_pkg, lru_if and lru_recency_list_evictor

module tb_lru_recency_list_evictor;
	import lru_pkg::*;

	localparam logic [KIND_W-1:0] KIND_ALBUM    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ARTIST   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_MUSIC    = 2'd2;
	localparam logic [KIND_W-1:0] KIND_PLAYLIST = 2'd3;

	localparam int IDLE_NONE  = 0;
	localparam int IDLE_LIGHT = 1;
	localparam int IDLE_HEAVY = 2;

	typedef struct packed {
		logic              evicted;
		logic [KIND_W-1:0] kind;
		logic [ID_W-1:0]   id;
		logic              hit;
	} access_outcome_t;

	logic clk = 1'b0;
	logic arst_n;

	lru_req_if req_ch ();
	lru_rsp_if rsp_ch ();
	lru_cfg_if cfg_ch ();

	lru_recency_list_evictor DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	entry_t             recency_list [MAX_ENTRIES+1];
	int                 list_len;
	logic [LIMIT_W-1:0] cap_limit;

	entry_t          pending_accesses [$];
	access_outcome_t predicted_outcomes [$];
	entry_t          next_access;
	access_outcome_t want;

	int req_gap;
	int rsp_hold;
	int req_idle_mode;
	int rsp_idle_mode;
	int errors;

	always #2 clk = ~clk;

	function automatic access_outcome_t touch_recency_list(entry_t key);
		int              lim;
		int              pos;
		access_outcome_t r;
		lim = (cap_limit > MAX_ENTRIES) ? MAX_ENTRIES : int'(cap_limit);
		r   = '0;
		pos = -1;
		for (int i = 0; i < list_len; i++)
			if (pos < 0 && recency_list[i] == key)
				pos = i;
		if (pos >= 0) begin
			r.hit = 1'b1;
			for (int i = pos; i < list_len - 1; i++)
				recency_list[i] = recency_list[i+1];
			recency_list[list_len-1] = key;
		end else begin
			recency_list[list_len] = key;
			list_len++;
		end
		if (list_len > lim) begin
			r.evicted = 1'b1;
			r.kind    = recency_list[0].kind;
			r.id      = recency_list[0].id;
			for (int i = 0; i < list_len - 1; i++)
				recency_list[i] = recency_list[i+1];
			list_len--;
		end
		return r;
	endfunction

	function automatic int draw_wait(int mode);
		case (mode)
			IDLE_NONE:  return 0;
			IDLE_LIGHT: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
			default:    return $urandom_range(0, 13);
		endcase
	endfunction

	function automatic entry_t random_key();
		entry_t k;
		k.kind = KIND_W'($urandom_range(0, 3));
		k.id   = $urandom_range(0, 1) ? ID_W'($urandom) : ID_W'($urandom_range(0, 15));
		return k;
	endfunction

	task automatic report_field(string name, logic [ID_W-1:0] exp_v, logic [ID_W-1:0] got_v);
		if (exp_v !== got_v) begin
			$display("%0t: %s expected %0h got %0h", $time, name, exp_v, got_v);
			errors++;
		end
	endtask

	// request driver
	always @(posedge clk) begin
		if (!arst_n) begin
			req_ch.valid      <= 1'b0;
			req_ch.entry_kind <= '0;
			req_ch.entry_id   <= '0;
			req_gap = 0;
		end else if (!req_ch.valid || req_ch.ready) begin
			if (req_ch.valid) begin
				predicted_outcomes.push_back(
					touch_recency_list({req_ch.entry_kind, req_ch.entry_id}));
				req_gap = draw_wait(req_idle_mode);
			end
			if (req_gap == 0 && pending_accesses.size() != 0) begin
				next_access = pending_accesses.pop_front();
				req_ch.valid      <= 1'b1;
				req_ch.entry_kind <= next_access.kind;
				req_ch.entry_id   <= next_access.id;
			end else begin
				req_ch.valid <= 1'b0;
				if (req_gap > 0)
					req_gap--;
			end
		end
	end

	// response monitor
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			rsp_hold = 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (predicted_outcomes.size() == 0) begin
					$display("%0t: response with no request outstanding, expected none got %0h",
						$time, {rsp_ch.evicted_valid, rsp_ch.evicted_kind,
						rsp_ch.evicted_id, rsp_ch.was_hit});
					errors++;
				end else begin
					want = predicted_outcomes.pop_front();
					report_field("evicted_valid", ID_W'(want.evicted),
						ID_W'(rsp_ch.evicted_valid));
					report_field("evicted_kind", ID_W'(want.kind),
						ID_W'(rsp_ch.evicted_kind));
					report_field("evicted_id", want.id, rsp_ch.evicted_id);
					report_field("was_hit", ID_W'(want.hit), ID_W'(rsp_ch.was_hit));
				end
				rsp_hold = draw_wait(rsp_idle_mode);
			end else if (rsp_hold > 0) begin
				rsp_hold--;
			end
			rsp_ch.ready <= (rsp_hold == 0);
		end
	end

	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_accesses.size() != 0 || req_ch.valid || predicted_outcomes.size() != 0);
	endtask

	task automatic write_limit(input logic [LIMIT_W-1:0] v);
		@(posedge clk);
		cfg_ch.valid          <= 1'b1;
		cfg_ch.capacity_limit <= v;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		cap_limit = v;
	endtask

	task automatic queue_batch(input int n_items, input int n_keys);
		entry_t keys [$];
		repeat (n_keys)
			keys.push_back(random_key());
		repeat (n_items) begin
			if ($urandom_range(0, 99) < 85)
				pending_accesses.push_back(keys[$urandom_range(0, n_keys - 1)]);
			else
				pending_accesses.push_back(random_key());
		end
	endtask

	initial begin
		logic [LIMIT_W-1:0] sweep [10];
		int                 eff;
		int                 n_keys;

		arst_n                = 1'b0;
		cfg_ch.valid          = 1'b0;
		cfg_ch.capacity_limit = '0;
		list_len              = 0;
		cap_limit             = CAPACITY_RESET;
		errors                = 0;
		req_idle_mode         = IDLE_LIGHT;
		rsp_idle_mode         = IDLE_HEAVY;

		repeat (9) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// reset limit: extremes, hits, same id under two kinds
		pending_accesses.push_back({KIND_ALBUM, 31'h0000_0000});
		pending_accesses.push_back({KIND_PLAYLIST, 31'h7FFF_FFFF});
		pending_accesses.push_back({KIND_ALBUM, 31'h0000_0000});
		pending_accesses.push_back({KIND_ARTIST, 31'h0000_0005});
		pending_accesses.push_back({KIND_MUSIC, 31'h0000_0005});
		pending_accesses.push_back({KIND_PLAYLIST, 31'h7FFF_FFFF});
		wait_drained();

		// lowered limit drains one entry per request
		write_limit(7'd1);
		pending_accesses.push_back({KIND_ARTIST, 31'h0000_0005});
		pending_accesses.push_back({KIND_MUSIC, 31'h0000_0005});
		pending_accesses.push_back({KIND_MUSIC, 31'h0000_0005});
		pending_accesses.push_back({KIND_ALBUM, 31'h0000_0000});
		wait_drained();

		// zero limit: hit empties the list, then a miss evicts itself
		write_limit(7'd0);
		pending_accesses.push_back({KIND_ALBUM, 31'h0000_0000});
		pending_accesses.push_back({KIND_ARTIST, 31'h2AAA_AAAA});
		pending_accesses.push_back({KIND_MUSIC, 31'h5555_5555});
		wait_drained();

		sweep[0] = 7'd127;
		sweep[1] = 7'd64;
		sweep[2] = 7'd65;
		sweep[3] = 7'd3;
		sweep[4] = 7'd2;
		sweep[5] = 7'd1;
		sweep[6] = 7'd0;
		sweep[7] = CAPACITY_RESET;
		sweep[8] = LIMIT_W'($urandom_range(0, 127));
		sweep[9] = LIMIT_W'($urandom_range(0, 127));

		foreach (sweep[p]) begin
			write_limit(sweep[p]);
			req_idle_mode = $urandom_range(IDLE_NONE, IDLE_HEAVY);
			rsp_idle_mode = $urandom_range(IDLE_NONE, IDLE_HEAVY);
			eff = (sweep[p] == 0) ? 1 : (sweep[p] > MAX_ENTRIES) ? MAX_ENTRIES : int'(sweep[p]);
			n_keys = $urandom_range(0, 1) ? eff + $urandom_range(0, 8)
				: $urandom_range(1, eff + 16);
			queue_batch(75, n_keys);
			wait_drained();
		end

		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#1000000;
		$display("status: fail");
		$finish;
	end

endmodule
